>>> rtl/core/aatc_pkg.sv
// Shared types, constants and fixed-point helpers of the two-link arm adaptive controller.
// Used by aatc_cordic, aatc_mul and adaptive_arm_torque_control; depends on nothing.
package aatc_pkg;

  // Field formats
  localparam int SIG_W      = 24;  // Q11.12 signals
  localparam int EST_W      = 40;  // Q15.24 estimates
  localparam int NUM_PARAMS = 5;
  localparam int SIG_FRAC   = 12;
  localparam int EST_FRAC   = 24;
  localparam int GAIN_FRAC  = 8;   // Q8.8 gains
  localparam int RATE_FRAC  = 24;  // Q0.24 adaptation rate
  localparam int UPD_SHIFT  = RATE_FRAC + SIG_FRAC - EST_FRAC;

  localparam int GAIN_W  = 16;
  localparam int RATE_W  = 24;
  localparam int LIMIT_W = 23;
  localparam int CFG_W   = 24;
  localparam int IN_W    = 240;
  localparam int OUT_W   = 256;

  // Shared multiplier operands and wide intermediate
  localparam int MA_W   = 41;
  localparam int MB_W   = 25;
  localparam int MP_W   = MA_W + MB_W;
  localparam int WIDE_W = 52;
  localparam int TERM_W = 40;  // unsaturated partial products of the regressor
  localparam int ACC_W  = 48;
  localparam int GACC_W = 50;
  localparam int ANG_W  = 25;

  // Register reset values
  localparam logic [GAIN_W-1:0]  LAMBDA_RST = 16'd1280;
  localparam logic [GAIN_W-1:0]  DAMP_RST   = 16'd3840;
  localparam logic [RATE_W-1:0]  RATE_RST   = 24'd83886;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 23'd204800;
  localparam logic signed [EST_W-1:0] EST_RST = 40'sd3355443;

  // CORDIC, angles in Q2.30
  localparam int CORDIC_STEPS = 20;
  localparam int ANG_SHIFT    = 30 - SIG_FRAC;
  localparam int RED_STEPS    = 11;  // restoring steps of the modulo-2pi reduction
  localparam int MAG_W        = 44;
  localparam int Z_W          = 36;
  localparam int XY_W         = 34;
  localparam logic [MAG_W-1:0]      TWO_PI_MAG = 44'd6746518853;
  localparam logic signed [Z_W-1:0] Z_PI       = 36'sd3373259426;
  localparam logic signed [Z_W-1:0] Z_TWO_PI   = 36'sd6746518853;
  localparam logic signed [Z_W-1:0] Z_HALF_PI  = 36'sd1686629713;
  localparam logic signed [XY_W-1:0] CORDIC_K  = 34'sd652032874;
  localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
    30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
    30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048
  };

  typedef enum logic [1:0] {
    REG_LAMBDA, REG_DAMPING, REG_RATE, REG_LIMIT
  } cfg_reg_t;

  typedef enum logic [2:0] {
    TS_IDLE, TS_ANGLE, TS_WAIT, TS_MUL, TS_WB, TS_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    CS_IDLE, CS_REDUCE, CS_FOLD, CS_ROTATE, CS_DONE
  } cordic_state_t;

  typedef enum logic [1:0] {
    ANG_Q2, ANG_Q1, ANG_SUM
  } angle_sel_t;

  // Micro-steps of the shared multiplier, in execution order
  typedef enum logic [5:0] {
    ST_DQR1, ST_DQR2, ST_DDQR1, ST_DDQR2,
    ST_M1, ST_M2, ST_T1, ST_T2, ST_M3, ST_M4, ST_T3, ST_M5,
    ST_A00, ST_A01, ST_A02, ST_A03, ST_A04, ST_TAU0,
    ST_A11, ST_A12, ST_A14, ST_TAU1,
    ST_G0, ST_U0, ST_G1, ST_G1B, ST_U1, ST_G2, ST_G2B, ST_U2,
    ST_G3, ST_U3, ST_G4, ST_G4B, ST_U4
  } step_t;

  typedef struct packed {
    logic                    done;
    logic signed [SIG_W-1:0] sin;
    logic signed [SIG_W-1:0] cos;
  } cordic_res_t;

  // Round half up at bit sh, then arithmetic shift
  function automatic logic signed [MP_W-1:0] rnd_prod(input logic signed [MP_W-1:0] v,
                                                      input int unsigned sh);
    logic signed [MP_W-1:0] half;
    half = MP_W'(1) <<< (sh - 1);
    return (v + half) >>> sh;
  endfunction

  function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = $signed({{(WIDE_W-SIG_W+1){1'b0}}, {(SIG_W-1){1'b1}}});
    lo = -hi - WIDE_W'(1);
    if (v > hi) return hi[SIG_W-1:0];
    else if (v < lo) return lo[SIG_W-1:0];
    return v[SIG_W-1:0];
  endfunction

  function automatic logic signed [EST_W-1:0] sat_est(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = $signed({{(WIDE_W-EST_W+1){1'b0}}, {(EST_W-1){1'b1}}});
    lo = -hi - WIDE_W'(1);
    if (v > hi) return hi[EST_W-1:0];
    else if (v < lo) return lo[EST_W-1:0];
    return v[EST_W-1:0];
  endfunction

endpackage

>>> rtl/core/aatc_mul.sv
// Shared signed multiplier with a registered product.
// Depends on aatc_pkg for operand widths.
module aatc_mul (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [aatc_pkg::MA_W-1:0] a,
  input  logic signed [aatc_pkg::MB_W-1:0] b,
  output logic signed [aatc_pkg::MP_W-1:0] p
);

  // one product per issue, held until the next
  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

>>> rtl/core/aatc_cordic.sv
// Iterative sine/cosine: modulo-2pi reduction by restoring subtraction, quadrant fold,
// then 20 CORDIC rotations, one per cycle. Depends on aatc_pkg.
module aatc_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [aatc_pkg::ANG_W-1:0] angle,
  output aatc_pkg::cordic_res_t             res
);

  aatc_pkg::cordic_state_t state, state_next;

  logic [aatc_pkg::MAG_W-1:0]       mag;
  logic                             neg_in;
  logic                             neg;
  logic [3:0]                       red_cnt;
  logic [4:0]                       rot_cnt;
  logic signed [aatc_pkg::Z_W-1:0]  z;
  logic signed [aatc_pkg::XY_W-1:0] x;
  logic signed [aatc_pkg::XY_W-1:0] y;

  logic [aatc_pkg::ANG_W-1:0]       ang_abs;
  logic [aatc_pkg::MAG_W-1:0]       sub_val;
  logic [aatc_pkg::MAG_W-1:0]       rem;
  logic signed [aatc_pkg::Z_W-1:0]  z_wrap;
  logic signed [aatc_pkg::Z_W-1:0]  z_fold;
  logic                             fold_neg;
  logic signed [aatc_pkg::Z_W-1:0]  atan_z;
  logic signed [aatc_pkg::XY_W-1:0] x_fin;
  logic signed [aatc_pkg::XY_W-1:0] y_fin;
  logic signed [aatc_pkg::XY_W-1:0] half_lsb;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      aatc_pkg::CS_IDLE:   if (start) state_next = aatc_pkg::CS_REDUCE;
      aatc_pkg::CS_REDUCE: if (red_cnt == 4'd0) state_next = aatc_pkg::CS_FOLD;
      aatc_pkg::CS_FOLD:   state_next = aatc_pkg::CS_ROTATE;
      aatc_pkg::CS_ROTATE: begin
        if (rot_cnt == 5'(aatc_pkg::CORDIC_STEPS - 1)) state_next = aatc_pkg::CS_DONE;
      end
      aatc_pkg::CS_DONE:   state_next = aatc_pkg::CS_IDLE;
      default:             state_next = aatc_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= aatc_pkg::CS_IDLE;
    else     state <= state_next;
  end

  // reduction and fold arithmetic
  always_comb begin
    ang_abs  = angle[aatc_pkg::ANG_W-1] ? aatc_pkg::ANG_W'(-angle) : aatc_pkg::ANG_W'(angle);
    sub_val  = aatc_pkg::TWO_PI_MAG << red_cnt;
    rem      = (neg_in && mag != '0) ? aatc_pkg::TWO_PI_MAG - mag : mag;
    z_wrap   = $signed(aatc_pkg::Z_W'(rem));
    if (z_wrap > aatc_pkg::Z_PI) z_wrap = z_wrap - aatc_pkg::Z_TWO_PI;
    z_fold   = z_wrap;
    fold_neg = 1'b0;
    if (z_wrap > aatc_pkg::Z_HALF_PI) begin
      z_fold   = z_wrap - aatc_pkg::Z_PI;
      fold_neg = 1'b1;
    end else if (z_wrap < -aatc_pkg::Z_HALF_PI) begin
      z_fold   = z_wrap + aatc_pkg::Z_PI;
      fold_neg = 1'b1;
    end
    atan_z = $signed({6'd0, aatc_pkg::ATAN_TAB[rot_cnt]});
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      aatc_pkg::CS_IDLE: begin
        mag     <= {1'b0, ang_abs, {aatc_pkg::ANG_SHIFT{1'b0}}};
        neg_in  <= angle[aatc_pkg::ANG_W-1];
        red_cnt <= 4'(aatc_pkg::RED_STEPS - 1);
      end
      aatc_pkg::CS_REDUCE: begin
        if (mag >= sub_val) mag <= mag - sub_val;
        red_cnt <= red_cnt - 4'd1;
      end
      aatc_pkg::CS_FOLD: begin
        z       <= z_fold;
        neg     <= fold_neg;
        x       <= aatc_pkg::CORDIC_K;
        y       <= '0;
        rot_cnt <= '0;
      end
      aatc_pkg::CS_ROTATE: begin
        if (!z[aatc_pkg::Z_W-1]) begin
          x <= x - (y >>> rot_cnt);
          y <= y + (x >>> rot_cnt);
          z <= z - atan_z;
        end else begin
          x <= x + (y >>> rot_cnt);
          y <= y - (x >>> rot_cnt);
          z <= z + atan_z;
        end
        rot_cnt <= rot_cnt + 5'd1;
      end
      aatc_pkg::CS_DONE: begin
        rot_cnt <= '0;
      end
      default: begin
        rot_cnt <= '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    x_fin    = neg ? -x : x;
    y_fin    = neg ? -y : y;
    half_lsb = aatc_pkg::XY_W'(1) <<< (aatc_pkg::ANG_SHIFT - 1);
    res.done = (state == aatc_pkg::CS_DONE);
    res.sin  = aatc_pkg::SIG_W'((y_fin + half_lsb) >>> aatc_pkg::ANG_SHIFT);
    res.cos  = aatc_pkg::SIG_W'((x_fin + half_lsb) >>> aatc_pkg::ANG_SHIFT);
  end

endmodule

>>> rtl/core/adaptive_arm_torque_control.sv
// Top level of the two-link arm adaptive torque controller: input capture, sequencer,
// configuration registers, estimate state. Uses aatc_pkg, aatc_cordic and aatc_mul.
//
//   channel | signals                      | request
//   input   | s_tvalid s_tready s_tdata    | measured and desired joint state
//   output  | m_tvalid m_tready m_tdata    | torques, clip flags, updated estimates
//   config  | cfg_we cfg_index cfg_data    | register write, taken when cfg_we is high
//
// Each request makes three sine/cosine runs on the single CORDIC unit (start, 11 reduction
// steps, fold, 20 rotations, done), then 35 micro-steps on the shared multiplier, each an
// issue state and a write-back state, then the output load state and the idle state.
// rst is synchronous; it restores the register defaults and the estimates to 0.2.
// s_tready is high only while no request is in work; a finished result waits in the output
// register and the next request is taken meanwhile.
module adaptive_arm_torque_control (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // pos_1, pos_2, vel_1, vel_2, pos_ref_1, pos_ref_2, vel_ref_1, vel_ref_2,
  // acc_ref_1, acc_ref_2 (24 bits each, lowest first)
  input  logic [aatc_pkg::IN_W-1:0]        s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // torque_1, torque_2 (24), clip_flags (2), estimate_1..estimate_5 (40 each), zero pad
  output logic [aatc_pkg::OUT_W-1:0]       m_tdata,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [aatc_pkg::CFG_W-1:0]       cfg_data
);

  localparam int SW = aatc_pkg::SIG_W;
  localparam int WW = aatc_pkg::WIDE_W;

  aatc_pkg::top_state_t state, state_next;
  aatc_pkg::step_t      step;
  aatc_pkg::angle_sel_t ang_sel;

  // configuration
  logic [aatc_pkg::GAIN_W-1:0]  lam;
  logic [aatc_pkg::GAIN_W-1:0]  kd;
  logic [aatc_pkg::RATE_W-1:0]  rate;
  logic [aatc_pkg::LIMIT_W-1:0] lim;

  // captured request
  logic signed [SW-1:0] q1, q2, dq1, dq2, qd1, qd2, vd1, vd2, ad1, ad2;
  // intermediate values
  logic signed [SW-1:0] dqr1, dqr2, ddqr1, ddqr2, s1, s2;
  logic signed [SW-1:0] sn1, sn2, cs2, sn12;
  logic signed [aatc_pkg::TERM_W-1:0] m1, m2, m3, m4, m5, t1, t2, t3;
  logic signed [aatc_pkg::ACC_W-1:0]  acc;
  logic signed [aatc_pkg::GACC_W-1:0] gacc;
  logic signed [aatc_pkg::EST_W-1:0]  th [aatc_pkg::NUM_PARAMS];
  logic signed [SW-1:0] tau0, tau1;
  logic [1:0]           flags;

  logic                              out_load;
  logic                              cor_start;
  logic signed [aatc_pkg::ANG_W-1:0] cor_angle;
  aatc_pkg::cordic_res_t             cor_res;
  logic                              mul_en;
  logic signed [aatc_pkg::MA_W-1:0]  a_op;
  logic signed [aatc_pkg::MB_W-1:0]  b_op;
  logic signed [aatc_pkg::MP_W-1:0]  p;

  logic signed [SW-1:0]  y01, y11, y12;
  logic signed [aatc_pkg::MA_W-1:0] g;
  logic signed [WW-1:0]  r8, r12, r24, rup;
  logic signed [WW-1:0]  tau_raw, lim_w;
  logic signed [SW-1:0]  tau_clip;
  logic                  tau_flag;
  logic signed [aatc_pkg::MA_W-1:0] lam_a, kd_a;
  logic signed [aatc_pkg::MB_W-1:0] rate_b;

  aatc_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (cor_angle),
    .res   (cor_res)
  );

  aatc_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (a_op),
    .b   (b_op),
    .p   (p)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      aatc_pkg::TS_IDLE:  if (s_tvalid) state_next = aatc_pkg::TS_ANGLE;
      aatc_pkg::TS_ANGLE: state_next = aatc_pkg::TS_WAIT;
      aatc_pkg::TS_WAIT: begin
        if (cor_res.done) begin
          state_next = (ang_sel == aatc_pkg::ANG_SUM) ? aatc_pkg::TS_MUL : aatc_pkg::TS_ANGLE;
        end
      end
      aatc_pkg::TS_MUL:   state_next = aatc_pkg::TS_WB;
      aatc_pkg::TS_WB: begin
        state_next = (step == aatc_pkg::ST_U4) ? aatc_pkg::TS_OUT : aatc_pkg::TS_MUL;
      end
      aatc_pkg::TS_OUT:   if (!m_tvalid || m_tready) state_next = aatc_pkg::TS_IDLE;
      default:            state_next = aatc_pkg::TS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= aatc_pkg::TS_IDLE;
    else     state <= state_next;
  end

  // state outputs
  always_comb begin
    s_tready  = (state == aatc_pkg::TS_IDLE);
    cor_start = (state == aatc_pkg::TS_ANGLE);
    mul_en    = (state == aatc_pkg::TS_MUL);
    out_load  = (state == aatc_pkg::TS_OUT) && (!m_tvalid || m_tready);
  end

  // angle for the CORDIC run
  always_comb begin
    unique case (ang_sel)
      aatc_pkg::ANG_Q2:  cor_angle = aatc_pkg::ANG_W'(q2);
      aatc_pkg::ANG_Q1:  cor_angle = aatc_pkg::ANG_W'(q1);
      aatc_pkg::ANG_SUM: cor_angle = aatc_pkg::ANG_W'(q1) + aatc_pkg::ANG_W'(q2);
      default:           cor_angle = aatc_pkg::ANG_W'(q1) + aatc_pkg::ANG_W'(q2);
    endcase
  end

  // regressor entries, gradient and rounded products
  always_comb begin
    y01 = aatc_pkg::sat_sig(WW'(m1) + WW'(m1) + WW'(m2) - WW'(m3) - WW'(m4));
    y11 = aatc_pkg::sat_sig(WW'(m1) + WW'(m5));
    y12 = aatc_pkg::sat_sig(WW'(ddqr1) + WW'(ddqr2));
    g   = aatc_pkg::MA_W'(aatc_pkg::rnd_prod(aatc_pkg::MP_W'(gacc), aatc_pkg::SIG_FRAC));
    r8  = WW'(aatc_pkg::rnd_prod(p, aatc_pkg::GAIN_FRAC));
    r12 = WW'(aatc_pkg::rnd_prod(p, aatc_pkg::SIG_FRAC));
    r24 = WW'(aatc_pkg::rnd_prod(p, aatc_pkg::EST_FRAC));
    rup = WW'(aatc_pkg::rnd_prod(p, aatc_pkg::UPD_SHIFT));
    lam_a  = $signed({{(aatc_pkg::MA_W - aatc_pkg::GAIN_W){1'b0}}, lam});
    kd_a   = $signed({{(aatc_pkg::MA_W - aatc_pkg::GAIN_W){1'b0}}, kd});
    rate_b = $signed({{(aatc_pkg::MB_W - aatc_pkg::RATE_W){1'b0}}, rate});
  end

  // torque clip
  always_comb begin
    tau_raw  = WW'(acc) - r8;
    lim_w    = $signed({{(WW - aatc_pkg::LIMIT_W){1'b0}}, lim});
    tau_clip = tau_raw[SW-1:0];
    tau_flag = 1'b0;
    if (tau_raw > lim_w) begin
      tau_clip = lim_w[SW-1:0];
      tau_flag = 1'b1;
    end else if (tau_raw < -lim_w) begin
      tau_clip = SW'(-lim_w);
      tau_flag = 1'b1;
    end
  end

  // multiplier operands per micro-step
  always_comb begin
    unique case (step)
      aatc_pkg::ST_DQR1:  begin a_op = lam_a; b_op = 25'(q1) - 25'(qd1); end
      aatc_pkg::ST_DQR2:  begin a_op = lam_a; b_op = 25'(q2) - 25'(qd2); end
      aatc_pkg::ST_DDQR1: begin a_op = lam_a; b_op = 25'(dq1) - 25'(vd1); end
      aatc_pkg::ST_DDQR2: begin a_op = lam_a; b_op = 25'(dq2) - 25'(vd2); end
      aatc_pkg::ST_M1:    begin a_op = 41'(cs2);   b_op = 25'(ddqr1); end
      aatc_pkg::ST_M2:    begin a_op = 41'(cs2);   b_op = 25'(ddqr2); end
      aatc_pkg::ST_T1:    begin a_op = 41'(dqr1);  b_op = 25'(dq2); end
      aatc_pkg::ST_T2:    begin a_op = 41'(dqr2);  b_op = 25'(dq1) + 25'(dq2); end
      aatc_pkg::ST_M3:    begin a_op = 41'(t1);    b_op = 25'(sn2); end
      aatc_pkg::ST_M4:    begin a_op = 41'(t2);    b_op = 25'(sn2); end
      aatc_pkg::ST_T3:    begin a_op = 41'(dqr1);  b_op = 25'(dq1); end
      aatc_pkg::ST_M5:    begin a_op = 41'(t3);    b_op = 25'(sn2); end
      aatc_pkg::ST_A00:   begin a_op = 41'(th[0]); b_op = 25'(ddqr1); end
      aatc_pkg::ST_A01:   begin a_op = 41'(th[1]); b_op = 25'(y01); end
      aatc_pkg::ST_A02:   begin a_op = 41'(th[2]); b_op = 25'(ddqr2); end
      aatc_pkg::ST_A03:   begin a_op = 41'(th[3]); b_op = 25'(sn1); end
      aatc_pkg::ST_A04:   begin a_op = 41'(th[4]); b_op = 25'(sn12); end
      aatc_pkg::ST_TAU0:  begin a_op = kd_a;       b_op = 25'(s1); end
      aatc_pkg::ST_A11:   begin a_op = 41'(th[1]); b_op = 25'(y11); end
      aatc_pkg::ST_A12:   begin a_op = 41'(th[2]); b_op = 25'(y12); end
      aatc_pkg::ST_A14:   begin a_op = 41'(th[4]); b_op = 25'(sn12); end
      aatc_pkg::ST_TAU1:  begin a_op = kd_a;       b_op = 25'(s2); end
      aatc_pkg::ST_G0:    begin a_op = 41'(ddqr1); b_op = 25'(s1); end
      aatc_pkg::ST_G1:    begin a_op = 41'(y01);   b_op = 25'(s1); end
      aatc_pkg::ST_G1B:   begin a_op = 41'(y11);   b_op = 25'(s2); end
      aatc_pkg::ST_G2:    begin a_op = 41'(ddqr2); b_op = 25'(s1); end
      aatc_pkg::ST_G2B:   begin a_op = 41'(y12);   b_op = 25'(s2); end
      aatc_pkg::ST_G3:    begin a_op = 41'(sn1);   b_op = 25'(s1); end
      aatc_pkg::ST_G4:    begin a_op = 41'(sn12);  b_op = 25'(s1); end
      aatc_pkg::ST_G4B:   begin a_op = 41'(sn12);  b_op = 25'(s2); end
      aatc_pkg::ST_U0, aatc_pkg::ST_U1, aatc_pkg::ST_U2, aatc_pkg::ST_U3,
      aatc_pkg::ST_U4:    begin a_op = g;          b_op = rate_b; end
      default:            begin a_op = g;          b_op = rate_b; end
    endcase
  end

  // configuration registers and estimate state
  always_ff @(posedge clk) begin
    if (rst) begin
      lam  <= aatc_pkg::LAMBDA_RST;
      kd   <= aatc_pkg::DAMP_RST;
      rate <= aatc_pkg::RATE_RST;
      lim  <= aatc_pkg::LIMIT_RST;
      for (int j = 0; j < aatc_pkg::NUM_PARAMS; j++) th[j] <= aatc_pkg::EST_RST;
    end else begin
      if (cfg_we) begin
        unique case (aatc_pkg::cfg_reg_t'(cfg_index))
          aatc_pkg::REG_LAMBDA:  lam  <= cfg_data[aatc_pkg::GAIN_W-1:0];
          aatc_pkg::REG_DAMPING: kd   <= cfg_data[aatc_pkg::GAIN_W-1:0];
          aatc_pkg::REG_RATE:    rate <= cfg_data[aatc_pkg::RATE_W-1:0];
          aatc_pkg::REG_LIMIT:   lim  <= cfg_data[aatc_pkg::LIMIT_W-1:0];
          default:               lim  <= lim;
        endcase
      end
      if (state == aatc_pkg::TS_WB) begin
        unique case (step)
          aatc_pkg::ST_U0: th[0] <= aatc_pkg::sat_est(WW'(th[0]) - rup);
          aatc_pkg::ST_U1: th[1] <= aatc_pkg::sat_est(WW'(th[1]) - rup);
          aatc_pkg::ST_U2: th[2] <= aatc_pkg::sat_est(WW'(th[2]) - rup);
          aatc_pkg::ST_U3: th[3] <= aatc_pkg::sat_est(WW'(th[3]) - rup);
          aatc_pkg::ST_U4: th[4] <= aatc_pkg::sat_est(WW'(th[4]) - rup);
          default:         th[0] <= th[0];
        endcase
      end
    end
  end

  // sequencer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= aatc_pkg::ST_DQR1;
      ang_sel <= aatc_pkg::ANG_Q2;
    end else begin
      if (s_tvalid && s_tready) begin
        step    <= aatc_pkg::ST_DQR1;
        ang_sel <= aatc_pkg::ANG_Q2;
      end else if (state == aatc_pkg::TS_WAIT && cor_res.done &&
                   ang_sel != aatc_pkg::ANG_SUM) begin
        ang_sel <= aatc_pkg::angle_sel_t'(ang_sel + 2'd1);
      end else if (state == aatc_pkg::TS_WB && step != aatc_pkg::ST_U4) begin
        step <= aatc_pkg::step_t'(step + 6'd1);
      end
    end
  end

  // request capture and sine/cosine results
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      q1  <= s_tdata[0*SW +: SW];
      q2  <= s_tdata[1*SW +: SW];
      dq1 <= s_tdata[2*SW +: SW];
      dq2 <= s_tdata[3*SW +: SW];
      qd1 <= s_tdata[4*SW +: SW];
      qd2 <= s_tdata[5*SW +: SW];
      vd1 <= s_tdata[6*SW +: SW];
      vd2 <= s_tdata[7*SW +: SW];
      ad1 <= s_tdata[8*SW +: SW];
      ad2 <= s_tdata[9*SW +: SW];
    end
    if (state == aatc_pkg::TS_WAIT && cor_res.done) begin
      unique case (ang_sel)
        aatc_pkg::ANG_Q2:  begin sn2 <= cor_res.sin; cs2 <= cor_res.cos; end
        aatc_pkg::ANG_Q1:  sn1  <= cor_res.sin;
        aatc_pkg::ANG_SUM: sn12 <= cor_res.sin;
        default:           sn12 <= cor_res.sin;
      endcase
    end
  end

  // micro-step write-back
  always_ff @(posedge clk) begin
    if (state == aatc_pkg::TS_WB) begin
      unique case (step)
        aatc_pkg::ST_DQR1: begin
          dqr1 <= aatc_pkg::sat_sig(WW'(vd1) - r8);
          s1   <= aatc_pkg::sat_sig(WW'(dq1) - WW'(aatc_pkg::sat_sig(WW'(vd1) - r8)));
        end
        aatc_pkg::ST_DQR2: begin
          dqr2 <= aatc_pkg::sat_sig(WW'(vd2) - r8);
          s2   <= aatc_pkg::sat_sig(WW'(dq2) - WW'(aatc_pkg::sat_sig(WW'(vd2) - r8)));
        end
        aatc_pkg::ST_DDQR1: ddqr1 <= aatc_pkg::sat_sig(WW'(ad1) - r8);
        aatc_pkg::ST_DDQR2: ddqr2 <= aatc_pkg::sat_sig(WW'(ad2) - r8);
        aatc_pkg::ST_M1:    m1 <= aatc_pkg::TERM_W'(r12);
        aatc_pkg::ST_M2:    m2 <= aatc_pkg::TERM_W'(r12);
        aatc_pkg::ST_T1:    t1 <= aatc_pkg::TERM_W'(r12);
        aatc_pkg::ST_T2:    t2 <= aatc_pkg::TERM_W'(r12);
        aatc_pkg::ST_M3:    m3 <= aatc_pkg::TERM_W'(r12);
        aatc_pkg::ST_M4:    m4 <= aatc_pkg::TERM_W'(r12);
        aatc_pkg::ST_T3:    t3 <= aatc_pkg::TERM_W'(r12);
        aatc_pkg::ST_M5:    m5 <= aatc_pkg::TERM_W'(r12);
        aatc_pkg::ST_A00, aatc_pkg::ST_A11: acc <= aatc_pkg::ACC_W'(r24);
        aatc_pkg::ST_A01, aatc_pkg::ST_A02, aatc_pkg::ST_A03, aatc_pkg::ST_A04,
        aatc_pkg::ST_A12, aatc_pkg::ST_A14: acc <= acc + aatc_pkg::ACC_W'(r24);
        aatc_pkg::ST_TAU0: begin tau0 <= tau_clip; flags[0] <= tau_flag; end
        aatc_pkg::ST_TAU1: begin tau1 <= tau_clip; flags[1] <= tau_flag; end
        aatc_pkg::ST_G0, aatc_pkg::ST_G1, aatc_pkg::ST_G2, aatc_pkg::ST_G3,
        aatc_pkg::ST_G4:   gacc <= aatc_pkg::GACC_W'(p);
        aatc_pkg::ST_G1B, aatc_pkg::ST_G2B,
        aatc_pkg::ST_G4B:  gacc <= gacc + aatc_pkg::GACC_W'(p);
        default:           gacc <= gacc;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'd0, th[4], th[3], th[2], th[1], th[0], flags, tau1, tau0};
    end
  end

  // a taken request always starts with the first sine/cosine run
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == aatc_pkg::TS_ANGLE && ang_sel == aatc_pkg::ANG_Q2))
    else $error("request accepted but angle run not started");

  // CORDIC results only arrive while the sequencer waits for them
  assert property (@(posedge clk) disable iff (rst)
    cor_res.done |-> (state == aatc_pkg::TS_WAIT))
    else $error("CORDIC result outside wait state");

  // a loaded result is presented on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid)
    else $error("result loaded but not presented");

  // multiplier issue alternates with write-back
  assert property (@(posedge clk) disable iff (rst)
    (state == aatc_pkg::TS_MUL) |=> (state == aatc_pkg::TS_WB && $stable(step)))
    else $error("micro-step sequence broken");

endmodule
